FILE: hdl/ofpq_pkg.sv
// shared types, constants and codes for the oldest-first priority queue
package ofpq_pkg;

	localparam int DEPTH    = 16;
	localparam int TAG_BITS = 32;

	localparam int AGE_W   = 8;
	localparam int TAG_W   = 32;
	localparam int COUNT_W = 5;
	localparam int IDX_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int FILL_W  = $clog2(DEPTH + 1);

	localparam logic FUNC_INSERT = 1'b0;
	localparam logic FUNC_REMOVE = 1'b1;

	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_FULL  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_SHIFT
	} state_t;

	typedef struct packed {
		logic load;
		logic shift;
	} cell_ctl_t;

endpackage

FILE: hdl/ofpq_req_if.sv
// request channel: operation code and entry payload
interface ofpq_req_if import ofpq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic               func;
	logic [AGE_W-1:0]   age;
	logic [TAG_W-1:0]   tag;

	modport source (output valid, func, age, tag, input ready);
	modport sink   (input valid, func, age, tag, output ready);
endinterface

FILE: hdl/ofpq_rsp_if.sv
// response channel: outcome, removed entry and fill level
interface ofpq_rsp_if import ofpq_pkg::*; ();
	logic               valid;
	logic               ready;
	logic [1:0]         status;
	logic [AGE_W-1:0]   removed_age;
	logic [TAG_W-1:0]   removed_tag;
	logic [COUNT_W-1:0] count;
	logic               is_empty;

	modport source (output valid, status, removed_age, removed_tag, count, is_empty,
		input ready);
	modport sink   (input valid, status, removed_age, removed_tag, count, is_empty,
		output ready);
endinterface

FILE: hdl/ofpq_cell.sv
// one storage cell of the entry chain: loads a new entry or takes its neighbor's
module ofpq_cell import ofpq_pkg::*; (
	input  logic                clk,
	input  cell_ctl_t           ctl,
	input  logic [AGE_W-1:0]    new_age,
	input  logic [TAG_BITS-1:0] new_tag,
	input  logic [AGE_W-1:0]    nxt_age,
	input  logic [TAG_BITS-1:0] nxt_tag,
	output logic [AGE_W-1:0]    age,
	output logic [TAG_BITS-1:0] tag
);

	logic [AGE_W-1:0]    age_q;
	logic [TAG_BITS-1:0] tag_q;

	always_ff @(posedge clk) begin
		if (ctl.load) begin
			age_q <= new_age;
			tag_q <= new_tag;
		end else if (ctl.shift) begin
			age_q <= nxt_age;
			tag_q <= nxt_tag;
		end
	end

	assign age = age_q;
	assign tag = tag_q;

endmodule

FILE: hdl/ofpq_ctrl.sv
// sequencer: fill count, max-age scan over the cells, response register
module ofpq_ctrl import ofpq_pkg::*; (
	input  logic                clk,
	input  logic                arst_n,
	ofpq_req_if.sink            req,
	ofpq_rsp_if.source          rsp,
	input  logic [AGE_W-1:0]    cell_age [DEPTH],
	input  logic [TAG_BITS-1:0] cell_tag [DEPTH],
	output cell_ctl_t           cell_ctl [DEPTH]
);

	state_t              state_q, state_d;
	logic [FILL_W-1:0]   fill_q;
	logic [IDX_W-1:0]    scan_q;
	logic [IDX_W-1:0]    best_idx_q;
	logic [AGE_W-1:0]    best_age_q;
	logic                rsp_valid_q;
	status_t             status_q;
	logic [AGE_W-1:0]    rm_age_q;
	logic [TAG_W-1:0]    rm_tag_q;
	logic [COUNT_W-1:0]  count_q;
	logic                empty_q;

	logic                accept;
	logic                is_full;
	logic                is_none;
	logic                ins_ok;
	logic [IDX_W-1:0]    last_idx;
	logic [AGE_W-1:0]    scan_age;

	assign is_full  = (fill_q == FILL_W'(DEPTH));
	assign is_none  = (fill_q == '0);
	assign last_idx = IDX_W'(fill_q - 1'b1);
	assign scan_age = cell_age[scan_q];

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE: begin
				if (accept && req.func == FUNC_REMOVE && !is_none) begin
					state_d = (fill_q == FILL_W'(1)) ? S_SHIFT : S_SCAN;
				end
			end
			S_SCAN: begin
				if (scan_q == last_idx) state_d = S_SHIFT;
			end
			S_SHIFT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	// outputs: handshake and per-cell controls
	always_comb begin
		req.ready = (state_q == S_IDLE) && (!rsp_valid_q || rsp.ready);
		accept    = req.valid && req.ready;
		ins_ok    = accept && req.func == FUNC_INSERT && !is_full;
		for (int j = 0; j < DEPTH; j++) begin
			cell_ctl[j].load  = ins_ok && (fill_q == FILL_W'(j));
			cell_ctl[j].shift = (state_q == S_SHIFT) && (IDX_W'(j) >= best_idx_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			fill_q      <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (ins_ok) begin
				fill_q <= fill_q + 1'b1;
			end else if (state_q == S_SHIFT) begin
				fill_q <= fill_q - 1'b1;
			end
			if (accept && (req.func == FUNC_INSERT || is_none)) begin
				rsp_valid_q <= 1'b1;
			end else if (state_q == S_SHIFT) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp.ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	// scan registers and response payload
	always_ff @(posedge clk) begin
		if (accept && req.func == FUNC_REMOVE) begin
			best_age_q <= cell_age[0];
			best_idx_q <= '0;
			scan_q     <= IDX_W'(1);
		end else if (state_q == S_SCAN) begin
			// strict compare keeps the earliest arrival on equal ages
			if (scan_age > best_age_q) begin
				best_age_q <= scan_age;
				best_idx_q <= scan_q;
			end
			scan_q <= scan_q + 1'b1;
		end

		if (accept) begin
			rm_age_q <= '0;
			rm_tag_q <= '0;
			if (req.func == FUNC_INSERT) begin
				status_q <= is_full ? ST_FULL : ST_OK;
				count_q  <= COUNT_W'(is_full ? fill_q : fill_q + 1'b1);
				empty_q  <= 1'b0;
			end else begin
				status_q <= ST_EMPTY;
				count_q  <= '0;
				empty_q  <= 1'b1;
			end
		end else if (state_q == S_SHIFT) begin
			status_q <= ST_OK;
			rm_age_q <= best_age_q;
			rm_tag_q <= TAG_W'(cell_tag[best_idx_q]);
			count_q  <= COUNT_W'(fill_q - 1'b1);
			empty_q  <= (fill_q == FILL_W'(1));
		end
	end

	assign rsp.valid       = rsp_valid_q;
	assign rsp.status      = status_q;
	assign rsp.removed_age = rm_age_q;
	assign rsp.removed_tag = rm_tag_q;
	assign rsp.count       = count_q;
	assign rsp.is_empty    = empty_q;

endmodule

FILE: hdl/oldest_first_priority_queue.sv
// top level of the oldest-first priority queue: cell chain and sequencer
//
// usage:
//   req carries one item per handshake: func (insert or remove), age, tag.
//   rsp returns exactly one item per request: status, removed_age,
//   removed_tag, count and is_empty, in request order.
//   entries live in a chain of cells in arrival order, cell 0 oldest.
// sequencing:
//   insert, and remove on an empty queue: result in the cycle after accept,
//   one such item per cycle while rsp.ready is high.
//   remove on a queue holding n entries: the sequencer scans the cells one
//   per cycle for the greatest age (earliest arrival wins ties), then the
//   winner and the cells behind it take their neighbor's entry in the
//   shift state, which registers the result; requests wait until then.
// reset:
//   arst_n empties the queue and clears the response valid flag; cell
//   contents are left as they are and only filled cells are ever read.
// stalls:
//   the response register holds its item while rsp.ready is low; a new
//   request is taken when idle and the register is free or being emptied.
module oldest_first_priority_queue import ofpq_pkg::*; (
	input  logic       clk,
	input  logic       arst_n,
	ofpq_req_if.sink   req,
	ofpq_rsp_if.source rsp
);

	logic [AGE_W-1:0]    cell_age [DEPTH];
	logic [TAG_BITS-1:0] cell_tag [DEPTH];
	cell_ctl_t           cell_ctl [DEPTH];
	logic [TAG_BITS-1:0] new_tag;

	// stored tags are TAG_BITS wide, equal to TAG_W, so the whole tag is kept
	assign new_tag = TAG_BITS'(req.tag);

	ofpq_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.req      (req),
		.rsp      (rsp),
		.cell_age (cell_age),
		.cell_tag (cell_tag),
		.cell_ctl (cell_ctl)
	);

	// chain of cells, each may take the entry of the cell behind it
	for (genvar j = 0; j < DEPTH; j++) begin : g_cell
		logic [AGE_W-1:0]    nxt_age;
		logic [TAG_BITS-1:0] nxt_tag;

		if (j == DEPTH - 1) begin : g_tail
			// last cell has no neighbor: it keeps its own entry
			assign nxt_age = cell_age[j];
			assign nxt_tag = cell_tag[j];
		end else begin : g_mid
			assign nxt_age = cell_age[j+1];
			assign nxt_tag = cell_tag[j+1];
		end

		ofpq_cell u_cell (
			.clk     (clk),
			.ctl     (cell_ctl[j]),
			.new_age (req.age),
			.new_tag (new_tag),
			.nxt_age (nxt_age),
			.nxt_tag (nxt_tag),
			.age     (cell_age[j]),
			.tag     (cell_tag[j])
		);
	end

endmodule
